FILE: sv/hop_channel_list_generator_assert.svh
// assertion macros for the checker file
`ifndef HOP_CHANNEL_LIST_GENERATOR_ASSERT_SVH
`define HOP_CHANNEL_LIST_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define HCLG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HCLG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/hclg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hclg_pkg;

    localparam logic [31:0] LCG_MUL     = 32'h0019660D;
    localparam logic [31:0] LCG_ADD     = 32'h3C6EF35F;
    localparam logic [7:0]  BAND_SPAN   = 8'd41;
    localparam logic [7:0]  MIN_GAP     = 8'd5;
    localparam logic [7:0]  CHAN_MIN    = 8'd1;
    localparam logic [7:0]  CHAN_MAX    = 8'd164;
    // ceil(2^37 / 41): exact quotient for every 32-bit dividend
    localparam logic [31:0] RECIP_41    = 32'd3352169597;
    localparam int unsigned RECIP_SHIFT = 37;
    localparam int unsigned STORE_DEPTH = 16;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned IN_W        = 40;
    localparam int unsigned OUT_W       = 16;

    typedef logic [7:0]        chan_t;
    typedef logic [SLOT_W-1:0] slot_t;

endpackage

`default_nettype wire

FILE: sv/hop_channel_list_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// hop channel table generator
// input stream (s_*): one request carries a 32-bit seed and an address byte;
//   s_tdata[31:0] seed, s_tdata[39:32] addr_byte
// output stream (m_*): one request per hop slot, in slot order;
//   m_tdata[7:0] channel (1..164), m_tdata[11:8] slot, upper bits zero,
//   m_tlast marks the final slot of the table
// each input request yields min(max(NUM_HOPS,1),16) output requests
// each candidate passes four steps (lcg step, shift, reciprocal multiply,
//   remainder), then a read and a check per earlier slot, since the accepted
//   channel store is a synchronous memory read once per compare; a rejected
//   candidate repeats the whole sequence for the same slot
// s_tready is high only between tables; a new table may start while the
//   last result of the previous one still waits in the output register
// when the receiver stalls, the next accepted channel waits in the sequencer
//   until the output register frees up; results are never dropped
// reset (rst_n low, asynchronous) returns to idle, clears the output valid
//   and the generator state; the channel store needs no clearing because a
//   run only reads entries it has already written

module hop_channel_list_generator #(
    parameter int NUM_HOPS = 16
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [hclg_pkg::IN_W-1:0]     s_tdata,   // seed[31:0], addr_byte[39:32]
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [hclg_pkg::OUT_W-1:0]    m_tdata,   // channel[7:0], slot[11:8], zero[15:12]
    output logic                          m_tlast
);

    import hclg_pkg::*;

    // table length clamped to 1 .. store depth
    localparam int unsigned TABLE_LEN = (NUM_HOPS < 1) ? 1 :
                                        (NUM_HOPS > int'(STORE_DEPTH)) ? STORE_DEPTH :
                                        NUM_HOPS;
    localparam slot_t LAST_SLOT = slot_t'(TABLE_LEN - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LCG,
        S_SHIFT,
        S_QUOT,
        S_REM,
        S_RD,
        S_CHK,
        S_EMIT
    } state_t;

    state_t      state_reg;
    logic [31:0] gen_state_reg;
    logic [1:0]  addr_reg;
    slot_t       slot_reg;
    slot_t       rd_idx_reg;
    logic [31:0] x_reg;
    logic [26:0] q_reg;
    chan_t       cand_reg;
    chan_t       rd_data_reg;
    logic        m_tvalid_reg;
    chan_t       out_chan_reg;
    slot_t       out_slot_reg;
    logic        out_last_reg;

    // accepted channels of the current run
    chan_t chan_mem [STORE_DEPTH];

    logic [31:0] gen_next;
    logic [31:0] x_next;
    logic [63:0] recip_prod;
    logic [26:0] q_next;
    logic [31:0] rem_full;
    logic [1:0]  band;
    chan_t       band_base;
    chan_t       cand_next;
    chan_t       chan_gap;
    logic        too_close;
    logic        out_free;
    logic        mem_we;
    logic        in_accept;

    // lcg step: one 32 x 21 constant multiply
    assign gen_next   = gen_state_reg * LCG_MUL + LCG_ADD;
    assign x_next     = gen_state_reg >> slot_reg;

    // x / 41 by reciprocal multiply, remainder from the registered quotient in the cycle after
    assign recip_prod = {32'd0, x_reg} * {32'd0, RECIP_41};
    assign q_next     = recip_prod[63:RECIP_SHIFT];
    assign rem_full   = x_reg - ({5'd0, q_reg} * 32'd41);

    // band = (bit-swapped low slot bits + addr) mod 4
    assign band       = {slot_reg[0], slot_reg[1]} + addr_reg;
    assign band_base  = {6'd0, band} * BAND_SPAN;
    assign cand_next  = band_base + CHAN_MIN + {2'd0, rem_full[5:0]};

    // distance to the stored channel read in the previous cycle
    assign chan_gap   = (cand_reg > rd_data_reg) ? (cand_reg - rd_data_reg)
                                                 : (rd_data_reg - cand_reg);
    assign too_close  = (chan_gap < MIN_GAP);

    assign out_free   = !m_tvalid_reg || m_tready;
    assign mem_we     = (state_reg == S_EMIT) && out_free;
    assign in_accept  = s_tvalid && s_tready;

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {4'd0, out_slot_reg, out_chan_reg};
    assign m_tlast    = out_last_reg;

    // store: writes go to the current slot; compares use only reads of earlier
    // slots, so a compared read never meets a write of the same entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            chan_mem[slot_reg] <= cand_reg;
        end
        rd_data_reg <= chan_mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gen_state_reg <= 32'd0;
            addr_reg      <= 2'd0;
            slot_reg      <= '0;
            rd_idx_reg    <= '0;
            x_reg         <= 32'd0;
            q_reg         <= 27'd0;
            cand_reg      <= 8'd0;
            m_tvalid_reg  <= 1'b0;
            out_chan_reg  <= 8'd0;
            out_slot_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // a new result loads the output register, else a taken one leaves it
            if (mem_we)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        gen_state_reg <= s_tdata[31:0];
                        addr_reg      <= s_tdata[33:32];
                        slot_reg      <= '0;
                        state_reg     <= S_LCG;
                    end
                end
                S_LCG:
                begin
                    gen_state_reg <= gen_next;
                    state_reg     <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    x_reg     <= x_next;
                    state_reg <= S_QUOT;
                end
                S_QUOT:
                begin
                    q_reg     <= q_next;
                    state_reg <= S_REM;
                end
                S_REM:
                begin
                    cand_reg   <= cand_next;
                    rd_idx_reg <= '0;
                    if (slot_reg == '0)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (too_close)
                    begin
                        state_reg <= S_LCG;
                    end
                    else if (slot_t'(rd_idx_reg + 1'b1) == slot_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        state_reg  <= S_RD;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_chan_reg <= cand_reg;
                        out_slot_reg <= slot_reg;
                        out_last_reg <= (slot_reg == LAST_SLOT);
                        if (slot_reg == LAST_SLOT)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            slot_reg  <= slot_reg + 1'b1;
                            state_reg <= S_LCG;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/hclg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "hop_channel_list_generator_assert.svh"

module hclg_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         s_tvalid,
    input wire                         s_tready,
    input wire [hclg_pkg::IN_W-1:0]    s_tdata,
    input wire                         m_tvalid,
    input wire                         m_tready,
    input wire [hclg_pkg::OUT_W-1:0]   m_tdata,
    input wire                         m_tlast
);

    import hclg_pkg::*;

    logic                chan_ok;
    logic                pad_ok;
    logic                mid_table;
    logic                out_wait;
    logic                in_wait;
    logic [OUT_W+1:0]    m_pack;
    logic [IN_W:0]       s_pack;

    assign chan_ok   = (m_tdata[7:0] >= CHAN_MIN) && (m_tdata[7:0] <= CHAN_MAX);
    assign pad_ok    = (m_tdata[15:12] == 4'd0);
    assign mid_table = m_tvalid && !m_tlast;
    assign out_wait  = m_tvalid && !m_tready;
    assign in_wait   = s_tvalid && !s_tready;
    assign m_pack    = {m_tvalid, m_tlast, m_tdata};
    assign s_pack    = {s_tvalid, s_tdata};

    // channel stays inside the four bands
    `HCLG_ASSERT_NOW(a_chan_range, clk, rst_n, m_tvalid, chan_ok, "channel out of range")

    // padding bits above the slot are zero
    `HCLG_ASSERT_NOW(a_pad_zero, clk, rst_n, m_tvalid, pad_ok, "nonzero padding in m_tdata")

    // input is not ready while a non-final result of a table waits at the output
    `HCLG_ASSERT_NOW(a_no_overlap, clk, rst_n, mid_table, !s_tready, "input ready mid-table")

    // a stalled result holds
    `HCLG_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_wait, $stable(m_pack), "stalled result changed")

    // a waiting input request holds
    `HCLG_ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait, $stable(s_pack), "waiting request changed")

endmodule

bind hop_channel_list_generator hclg_checker u_hclg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
